[src/odtb_pkg.sv]
package odtb_pkg;

    localparam int ID_W   = 4;
    localparam int DUR_W  = 32;
    localparam int TIME_W = 48;

    // Input function codes
    localparam logic [1:0] FUNC_ARM     = 2'd0;
    localparam logic [1:0] FUNC_CLEAR   = 2'd1;
    localparam logic [1:0] FUNC_OBSERVE = 2'd2;

    // Classified operations carried through the queue
    localparam logic [1:0] OP_NOP     = 2'd0;
    localparam logic [1:0] OP_ARM     = 2'd1;
    localparam logic [1:0] OP_CLEAR   = 2'd2;
    localparam logic [1:0] OP_OBSERVE = 2'd3;

    // tval holds the new deadline for an arm, the current time for an observe
    typedef struct packed {
        logic [1:0]        op;
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] tval;
    } t_cmd;

endpackage

[src/ordered_deadline_timer_bank_unit.sv]
// Channel   Direction  Handshake          Beat payload
// input     in         i_valid / o_stall  i_func, i_timer_id, i_duration, i_now
// output    out        o_valid / i_stall  o_expired, o_expired_id
//
// Every input beat yields exactly one output beat. The front classifies a beat and
// adds now + duration in the cycle it is accepted, then parks it in a two-entry queue.
// The back moves arm, clear and ignored beats from IDLE straight to DONE; an observe
// that examines k list entries (k up to 15) reads one deadline per entry in SCAN.
// Reset (synchronous, active low) empties the queue, the armed list and the output beat.
// A stall on the output holds the back in its hand-off cycle; the queue keeps
// accepting until it is full.
module ordered_deadline_timer_bank_unit #(
    parameter int NUM_TIMERS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [1:0]                  i_func,
    input  logic [odtb_pkg::ID_W-1:0]   i_timer_id,
    input  logic [odtb_pkg::DUR_W-1:0]  i_duration,
    input  logic [odtb_pkg::TIME_W-1:0] i_now,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic                        o_expired,
    output logic [odtb_pkg::ID_W-1:0]   o_expired_id
);
    import odtb_pkg::*;

    // Command hand-off between front and back
    logic cmd_valid;
    t_cmd cmd;
    logic cmd_pop;

    // Front: decode, compute the new deadline, queue the beat
    odtb_front #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_func      (i_func),
        .i_timer_id  (i_timer_id),
        .i_duration  (i_duration),
        .i_now       (i_now),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    // Back: maintain the arm-order list and deadlines, scan for expiry,
    // hold the result in the output register
    odtb_back #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (cmd_valid),
        .i_cmd        (cmd),
        .o_cmd_pop    (cmd_pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_expired    (o_expired),
        .o_expired_id (o_expired_id)
    );

endmodule

[src/odtb_ram.sv]
module odtb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[src/odtb_front.sv]
module odtb_front #(
    parameter int NUM_TIMERS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [1:0]                  i_func,
    input  logic [odtb_pkg::ID_W-1:0]   i_timer_id,
    input  logic [odtb_pkg::DUR_W-1:0]  i_duration,
    input  logic [odtb_pkg::TIME_W-1:0] i_now,
    output logic                        o_cmd_valid,
    output odtb_pkg::t_cmd              o_cmd,
    input  logic                        i_cmd_pop
);
    import odtb_pkg::*;

    localparam int Q_DEPTH = 2;
    localparam int PTR_W   = $clog2(Q_DEPTH);
    localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

    t_cmd              r_q [Q_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [QCNT_W-1:0] r_cnt;

    t_cmd cmd_in;
    logic id_ok;
    logic push;
    logic pop;

    // Classify the beat and form its time value
    always_comb begin
        id_ok       = (i_timer_id != '0) && (int'(i_timer_id) < NUM_TIMERS);
        cmd_in.op   = OP_NOP;
        cmd_in.id   = i_timer_id;
        cmd_in.tval = i_now;
        case (i_func)
            FUNC_ARM: begin
                if (id_ok) begin
                    cmd_in.op = OP_ARM;
                end
                cmd_in.tval = i_now + TIME_W'(i_duration);
            end
            FUNC_CLEAR: begin
                if (id_ok) begin
                    cmd_in.op = OP_CLEAR;
                end
            end
            FUNC_OBSERVE: begin
                cmd_in.op = OP_OBSERVE;
            end
            default: begin
                cmd_in.op = OP_NOP;
            end
        endcase
    end

    assign o_stall     = (r_cnt == QCNT_W'(Q_DEPTH));
    assign push        = i_valid && !o_stall;
    assign o_cmd_valid = (r_cnt != '0);
    assign pop         = o_cmd_valid && i_cmd_pop;
    assign o_cmd       = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= cmd_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + QCNT_W'(1);
            end else if (pop && !push) begin
                r_cnt <= r_cnt - QCNT_W'(1);
            end
        end
    end

endmodule

[src/odtb_back.sv]
module odtb_back #(
    parameter int NUM_TIMERS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cmd_valid,
    input  odtb_pkg::t_cmd            i_cmd,
    output logic                      o_cmd_pop,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic                      o_expired,
    output logic [odtb_pkg::ID_W-1:0] o_expired_id
);
    import odtb_pkg::*;

    localparam int ID_SPAN = 1 << ID_W;
    localparam int LIST_D  = (NUM_TIMERS < ID_SPAN) ? NUM_TIMERS : ID_SPAN;
    localparam int IDX_W   = $clog2(LIST_D);
    localparam int CNT_W   = $clog2(LIST_D + 1);
    localparam int AW      = $clog2(NUM_TIMERS);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]        r_state, n_state;
    t_cmd              r_cmd, n_cmd;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [ID_W-1:0]   r_walk_id, n_walk_id;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [ID_W-1:0]   r_order [LIST_D];
    logic [ID_W-1:0]   n_order [LIST_D];
    logic              r_exp, n_exp;
    logic [ID_W-1:0]   r_eid, n_eid;
    logic              r_out_valid;
    logic              r_out_exp;
    logic [ID_W-1:0]   r_out_id;

    logic              hit_any;
    logic [IDX_W-1:0]  hit_pos;
    logic              do_remove;
    logic [IDX_W-1:0]  rm_pos;
    logic [IDX_W-1:0]  idx_nx;
    logic              ram_we;
    logic [TIME_W-1:0] ram_rdata;
    logic              out_load;

    odtb_ram #(
        .WIDTH (TIME_W),
        .DEPTH (NUM_TIMERS)
    ) u_deadline (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (AW'(i_cmd.id)),
        .i_wdata (i_cmd.tval),
        .i_raddr (AW'(n_walk_id)),
        .o_rdata (ram_rdata)
    );

    // Look up the head command's timer among the armed entries
    always_comb begin
        hit_any = 1'b0;
        hit_pos = '0;
        for (int i = 0; i < LIST_D; i++) begin
            if ((CNT_W'(i) < r_count) && (r_order[i] == i_cmd.id)) begin
                hit_any = 1'b1;
                hit_pos = hit_pos | IDX_W'(i);
            end
        end
    end

    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_idx     = r_idx;
        n_walk_id = r_walk_id;
        n_count   = r_count;
        n_exp     = r_exp;
        n_eid     = r_eid;
        n_order   = r_order;
        o_cmd_pop = 1'b0;
        do_remove = 1'b0;
        rm_pos    = '0;
        ram_we    = 1'b0;
        out_load  = 1'b0;
        idx_nx    = r_idx + IDX_W'(1);

        case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_cmd     = i_cmd;
                    n_exp     = 1'b0;
                    n_eid     = '0;
                    n_state   = ST_DONE;
                    case (i_cmd.op)
                        OP_ARM: begin
                            ram_we = 1'b1;
                            if (!hit_any && (r_count < CNT_W'(LIST_D))) begin
                                n_order[r_count[IDX_W-1:0]] = i_cmd.id;
                                n_count = r_count + CNT_W'(1);
                            end
                        end
                        OP_CLEAR: begin
                            if (hit_any) begin
                                do_remove = 1'b1;
                                rm_pos    = hit_pos;
                            end
                        end
                        OP_OBSERVE: begin
                            if (r_count != '0) begin
                                n_idx     = '0;
                                n_walk_id = r_order[0];
                                n_state   = ST_SCAN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (r_cmd.tval >= ram_rdata) begin
                    do_remove = 1'b1;
                    rm_pos    = r_idx;
                    n_exp     = 1'b1;
                    n_eid     = r_walk_id;
                    n_state   = ST_DONE;
                end else if ((CNT_W'(r_idx) + CNT_W'(1)) < r_count) begin
                    n_idx     = idx_nx;
                    n_walk_id = r_order[idx_nx];
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || !i_stall) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // Close the gap left by a removed entry
        if (do_remove) begin
            for (int i = 0; i < LIST_D - 1; i++) begin
                if (IDX_W'(i) >= rm_pos) begin
                    n_order[i] = r_order[i + 1];
                end
            end
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_idx     <= n_idx;
        r_walk_id <= n_walk_id;
        r_order   <= n_order;
        r_exp     <= n_exp;
        r_eid     <= n_eid;
        if (out_load) begin
            r_out_exp <= r_exp;
            r_out_id  <= r_eid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid      = r_out_valid;
    assign o_expired    = r_out_exp;
    assign o_expired_id = r_out_id;

endmodule
